FILE: design/ccc_pkg.sv
// ----------------------------------------------------------------------------
// ccc_pkg
// Shared constants and types of the cc/cv charge controller: phase codes,
// request codes, register indexes and cell store geometry.
// ----------------------------------------------------------------------------
`default_nettype none

package ccc_pkg;

  // cell store geometry
  localparam int MAX_CELLS = 128;
  localparam int CELL_AW   = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int CELL_CW   = $clog2(MAX_CELLS + 1);
  localparam int CELL_W    = 16;

  // configuration port
  localparam int CFG_DW = 32;
  typedef logic [2:0] cfg_idx_t;

  localparam cfg_idx_t REG_CELL_MAX     = 3'd0;
  localparam cfg_idx_t REG_CC_VOLTAGE   = 3'd1;
  localparam cfg_idx_t REG_CV_VOLTAGE   = 3'd2;
  localparam cfg_idx_t REG_CHARGE_CUR   = 3'd3;
  localparam cfg_idx_t REG_CV_DONE_CUR  = 3'd4;
  localparam cfg_idx_t REG_CV_DONE_TIME = 3'd5;
  localparam cfg_idx_t REG_BAL_THRESH   = 3'd6;
  localparam cfg_idx_t REG_NUM_CELLS    = 3'd7;

  // charge phases
  typedef logic [2:0] phase_t;

  localparam phase_t PH_OFF  = 3'd0;
  localparam phase_t PH_INIT = 3'd1;
  localparam phase_t PH_CC   = 3'd2;
  localparam phase_t PH_CV   = 3'd3;
  localparam phase_t PH_BAL  = 3'd4;
  localparam phase_t PH_DONE = 3'd5;

  // mode requests
  typedef logic [1:0] req_t;

  localparam req_t REQ_CHARGE  = 2'd0;
  localparam req_t REQ_BALANCE = 2'd1;

  // item kinds
  localparam logic MODE_CELL_WRITE = 1'b0;
  localparam logic MODE_STEP       = 1'b1;

  localparam logic [15:0] CELL_MAX_RESET = 16'd4200;

endpackage

`default_nettype wire

FILE: design/ccc_in_if.sv
// ----------------------------------------------------------------------------
// ccc_in_if
// Input channel of the charge controller: cell writes and control steps.
// ----------------------------------------------------------------------------
`default_nettype none

interface ccc_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [6:0]  cell_index;
  logic [15:0] cell_mv;
  logic [1:0]  request;
  logic        contactor_fb;
  logic        charger_is_on;
  logic        bal_hold;
  logic [15:0] hi_cell_mv;
  logic [19:0] pack_current_ma;
  logic [31:0] ms_ticks;
  logic [15:0] bal_target_mv;

  modport source (
    output valid, mode, cell_index, cell_mv, request, contactor_fb,
           charger_is_on, bal_hold, hi_cell_mv, pack_current_ma,
           ms_ticks, bal_target_mv,
    input  ready
  );

  modport sink (
    input  valid, mode, cell_index, cell_mv, request, contactor_fb,
           charger_is_on, bal_hold, hi_cell_mv, pack_current_ma,
           ms_ticks, bal_target_mv,
    output ready
  );
endinterface

`default_nettype wire

FILE: design/ccc_out_if.sv
// ----------------------------------------------------------------------------
// ccc_out_if
// Result channel of the charge controller: commands and new phase.
// ----------------------------------------------------------------------------
`default_nettype none

interface ccc_out_if;
  logic        valid;
  logic        ready;
  logic        contactor_cmd;
  logic        charger_enable;
  logic [22:0] voltage_req_mv;
  logic [19:0] curr_setpt_ma;
  logic [2:0]  phase_out;

  modport source (
    output valid, contactor_cmd, charger_enable, voltage_req_mv,
           curr_setpt_ma, phase_out,
    input  ready
  );

  modport sink (
    input  valid, contactor_cmd, charger_enable, voltage_req_mv,
           curr_setpt_ma, phase_out,
    output ready
  );
endinterface

`default_nettype wire

FILE: design/ccc_ram.sv
// ----------------------------------------------------------------------------
// ccc_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ccc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: design/cc_cv_charge_controller.sv
// ----------------------------------------------------------------------------
// cc_cv_charge_controller
// Battery-pack charge sequencer: off, init, cc, cv, balance and done phases.
// Cell writes fill a cell voltage RAM that a balance check in done walks.
// ----------------------------------------------------------------------------
// A cell write gives no result; a control step other than a balance request
//   in done puts its result in the output register at the edge it is accepted.
// A balance request in done walks the cell RAM one read per cycle over the
//   first n = min(num_cells, MAX_CELLS) cells, then writes the result register.
// One item in flight; the next is taken when not scanning and the output register is free.
// Reset: registers to defaults, phase off, cell valid bits cleared at once.
`default_nettype none

module cc_cv_charge_controller (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire ccc_pkg::cfg_idx_t cfg_index,
  input  wire logic [ccc_pkg::CFG_DW-1:0] cfg_data,
  ccc_in_if.sink                 step_in,
  ccc_out_if.source              step_out
);

  import ccc_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  // configuration registers
  logic [15:0] cell_limit_mv;
  logic [22:0] cc_voltage_mv;
  logic [22:0] cv_voltage_mv;
  logic [19:0] chg_current_ma;
  logic [19:0] cv_done_current_ma;
  logic [31:0] cv_done_time_ms;
  logic [15:0] bal_margin_mv;
  logic [7:0]  num_cells;

  // sequencer state
  phase_t      phase;
  logic [31:0] last_high_tick;
  logic        st;

  // balance scan
  logic [CELL_CW-1:0] issue_cnt;
  logic [CELL_CW-1:0] scan_n;
  logic [CELL_CW-1:0] scan_n_next;
  logic               rd_pend;
  logic               rd_vbit;
  logic               hit;
  logic [16:0]        scan_limit;
  logic               issue_more;
  logic               scan_done;

  // cell store
  logic [MAX_CELLS-1:0] cell_valid;
  logic                 ram_we;
  logic [CELL_AW-1:0]   ram_waddr;
  logic [CELL_AW-1:0]   ram_raddr;
  logic [CELL_W-1:0]    ram_rdata;

  // output register
  logic        out_valid;
  logic        res_close;
  logic        res_enable;
  logic [22:0] res_volt;
  logic [19:0] res_curr;
  phase_t      res_state;

  // handshake
  logic accept;
  logic step_acc;
  logic out_take;

  // step evaluation
  phase_t      p_req;
  phase_t      phase_next;
  logic        c_close;
  logic        c_enable;
  logic [22:0] c_volt;
  logic [19:0] c_curr;
  logic [31:0] last_high_next;
  logic        need_scan;
  logic        want_close;
  logic        below_max;
  logic [31:0] tick_diff;

  assign step_in.ready = (st == ST_IDLE) && (!out_valid || step_out.ready);
  assign accept        = step_in.valid && step_in.ready;
  assign step_acc      = accept && (step_in.mode == MODE_STEP);
  assign out_take      = out_valid && step_out.ready;

  assign step_out.valid          = out_valid;
  assign step_out.contactor_cmd  = res_close;
  assign step_out.charger_enable = res_enable;
  assign step_out.voltage_req_mv = res_volt;
  assign step_out.curr_setpt_ma  = res_curr;
  assign step_out.phase_out      = res_state;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_limit_mv      <= CELL_MAX_RESET;
      cc_voltage_mv      <= '0;
      cv_voltage_mv      <= '0;
      chg_current_ma     <= '0;
      cv_done_current_ma <= '0;
      cv_done_time_ms    <= '0;
      bal_margin_mv      <= '0;
      num_cells          <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CELL_MAX:     cell_limit_mv      <= cfg_data[15:0];
        REG_CC_VOLTAGE:   cc_voltage_mv      <= cfg_data[22:0];
        REG_CV_VOLTAGE:   cv_voltage_mv      <= cfg_data[22:0];
        REG_CHARGE_CUR:   chg_current_ma     <= cfg_data[19:0];
        REG_CV_DONE_CUR:  cv_done_current_ma <= cfg_data[19:0];
        REG_CV_DONE_TIME: cv_done_time_ms    <= cfg_data[31:0];
        REG_BAL_THRESH:   bal_margin_mv      <= cfg_data[15:0];
        REG_NUM_CELLS:    num_cells          <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // cells covered by the balance check
  always_comb begin
    if (32'(num_cells) < 32'(MAX_CELLS)) begin
      scan_n_next = CELL_CW'(num_cells);
    end else begin
      scan_n_next = CELL_CW'(MAX_CELLS);
    end
  end

  assign below_max = step_in.hi_cell_mv < cell_limit_mv;
  assign tick_diff = step_in.ms_ticks - last_high_tick;

  // mode request, then phase logic
  always_comb begin
    p_req          = (phase > PH_DONE) ? PH_OFF : phase;
    phase_next     = PH_OFF;
    c_close        = 1'b0;
    c_enable       = 1'b0;
    c_volt         = '0;
    c_curr         = '0;
    last_high_next = last_high_tick;
    need_scan      = 1'b0;
    want_close     = (step_in.request == REQ_CHARGE);

    if (step_in.request == REQ_CHARGE) begin
      if (p_req == PH_OFF || p_req == PH_BAL) begin
        p_req = PH_INIT;
      end
    end else if (step_in.request == REQ_BALANCE) begin
      if (p_req == PH_OFF || p_req == PH_CC || p_req == PH_CV) begin
        p_req = PH_INIT;
      end
    end else if (p_req != PH_OFF) begin
      p_req = PH_DONE;
    end

    phase_next = p_req;
    case (p_req)
      PH_INIT: begin
        c_close = want_close;
        if (step_in.contactor_fb == want_close) begin
          if (step_in.request == REQ_CHARGE) begin
            phase_next = below_max ? PH_CC : PH_CV;
          end else if (step_in.request == REQ_BALANCE) begin
            phase_next = PH_BAL;
          end
        end
      end
      PH_CC: begin
        c_close  = 1'b1;
        c_enable = 1'b1;
        c_curr   = chg_current_ma;
        if (!below_max) begin
          phase_next = PH_CV;
          c_volt     = cv_voltage_mv;
        end else begin
          c_volt = cc_voltage_mv;
        end
        if (!step_in.contactor_fb) begin
          c_enable   = 1'b0;
          c_volt     = '0;
          c_curr     = '0;
          phase_next = PH_INIT;
        end
      end
      PH_CV: begin
        c_close  = 1'b1;
        c_enable = 1'b1;
        c_curr   = chg_current_ma;
        if (below_max) begin
          phase_next = PH_CC;
          c_volt     = cc_voltage_mv;
        end else begin
          c_volt = cv_voltage_mv;
          if (step_in.pack_current_ma >= cv_done_current_ma) begin
            last_high_next = step_in.ms_ticks;
          end
        end
        if (!below_max && step_in.pack_current_ma < cv_done_current_ma &&
            tick_diff >= cv_done_time_ms) begin
          // low current held long enough: charging complete
          c_close    = 1'b0;
          c_enable   = 1'b0;
          c_volt     = '0;
          c_curr     = '0;
          phase_next = PH_DONE;
        end else if (!step_in.contactor_fb) begin
          c_enable   = 1'b0;
          c_volt     = '0;
          c_curr     = '0;
          phase_next = PH_INIT;
        end
      end
      PH_BAL: begin
        if (!step_in.bal_hold) begin
          phase_next = PH_DONE;
        end
        if (step_in.contactor_fb) begin
          phase_next = PH_INIT;
        end
      end
      PH_DONE: begin
        if (step_in.request == REQ_CHARGE) begin
          if (below_max) begin
            phase_next = PH_INIT;
          end
        end else if (step_in.request == REQ_BALANCE) begin
          need_scan = 1'b1;
        end else if (!step_in.contactor_fb && !step_in.charger_is_on) begin
          phase_next = PH_OFF;
        end
      end
      default: ;
    endcase
  end

  // cell store writes
  assign ram_we    = accept && (step_in.mode == MODE_CELL_WRITE) &&
                     (32'(step_in.cell_index) < 32'(MAX_CELLS));
  assign ram_waddr = CELL_AW'(step_in.cell_index);
  assign ram_raddr = issue_cnt[CELL_AW-1:0];

  assign issue_more = issue_cnt < scan_n;
  assign scan_done  = (st == ST_SCAN) && !issue_more && !rd_pend;

  ccc_ram #(
    .WIDTH (CELL_W),
    .DEPTH (MAX_CELLS)
  ) u_cell_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (step_in.cell_mv),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // valid bits: an unwritten cell reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_valid <= '0;
    end else if (ram_we) begin
      cell_valid[ram_waddr] <= 1'b1;
    end
  end

  // sequencer and balance scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      st             <= ST_IDLE;
      phase          <= PH_OFF;
      last_high_tick <= '0;
      rd_pend        <= 1'b0;
    end else begin
      unique case (st)
        ST_IDLE: begin
          rd_pend <= 1'b0;
          if (step_acc) begin
            phase          <= phase_next;
            last_high_tick <= last_high_next;
            if (need_scan) begin
              st <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          rd_pend <= issue_more;
          if (scan_done) begin
            st    <= ST_IDLE;
            phase <= hit ? PH_INIT : PH_DONE;
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  // scan datapath
  always_ff @(posedge clk) begin
    if (st == ST_IDLE) begin
      issue_cnt  <= '0;
      scan_n     <= scan_n_next;
      hit        <= 1'b0;
      scan_limit <= {1'b0, step_in.bal_target_mv} + {1'b0, bal_margin_mv};
    end else begin
      if (issue_more) begin
        issue_cnt <= issue_cnt + CELL_CW'(1);
        rd_vbit   <= cell_valid[ram_raddr];
      end
      if (rd_pend && rd_vbit && ({1'b0, ram_rdata} > scan_limit)) begin
        hit <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((step_acc && !need_scan) || scan_done) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_done) begin
      res_close  <= 1'b0;
      res_enable <= 1'b0;
      res_volt   <= '0;
      res_curr   <= '0;
      res_state  <= hit ? PH_INIT : PH_DONE;
    end else if (step_acc && !need_scan) begin
      res_close  <= c_close;
      res_enable <= c_enable;
      res_volt   <= c_volt;
      res_curr   <= c_curr;
      res_state  <= phase_next;
    end
  end

endmodule

`default_nettype wire

FILE: tb/cc_cv_charge_controller_check.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cc_cv_charge_controller_check
// Watches the request and result channels of the charge controller. It keeps
// its own copy of the registers, the charge phase, the high-current tick and
// the cell voltage store, predicts the commands for every control step and
// compares each result, field by field and in order, with the prediction.
// ---------------------------------------------------------------------------
module cc_cv_charge_controller_check (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  ccc_pkg::cfg_idx_t          cfg_index,
  input  logic [ccc_pkg::CFG_DW-1:0] cfg_data,
  ccc_in_if                          step_in,
  ccc_out_if                         step_out,
  output int                         failures,
  output int                         pending
);

  import ccc_pkg::*;

  typedef struct packed {
    logic        close;
    logic        enable;
    logic [22:0] volt_mv;
    logic [19:0] curr_ma;
    phase_t      state;
  } charger_cmd_t;

  // register copies
  logic [15:0] cell_lim_mv;
  logic [22:0] cc_volt_mv;
  logic [22:0] cv_volt_mv;
  logic [19:0] chg_curr_ma;
  logic [19:0] taper_curr_ma;
  logic [31:0] taper_time_ms;
  logic [15:0] bal_margin_mv;
  logic [7:0]  cells_used;

  // sequencer state
  phase_t      cur_phase;
  logic [31:0] last_high_tick;
  logic [CELL_W-1:0] cell_mv_store [MAX_CELLS];

  charger_cmd_t predicted_cmds [$];
  int mismatch_cnt = 0;

  assign failures = mismatch_cnt;

  function automatic charger_cmd_t make_cmd(logic close, logic enable,
                                            logic [22:0] volt, logic [19:0] curr);
    charger_cmd_t c;
    c = '0;
    c.close   = close;
    c.enable  = enable;
    c.volt_mv = volt;
    c.curr_ma = curr;
    return c;
  endfunction

  // one control step: mode request first, then the phase logic
  function automatic charger_cmd_t advance_charge_phase(
    req_t req, logic closed, logic chg_on, logic bal_req, logic [15:0] cmax,
    logic [19:0] cur, logic [31:0] ticks, logic [15:0] bal_mv);
    phase_t       ph;
    charger_cmd_t cmd;
    logic         want;
    logic         finished;
    logic [31:0]  elapsed;
    logic [16:0]  bal_limit;
    int           n;
    ph  = (cur_phase > PH_DONE) ? PH_OFF : cur_phase;
    cmd = '0;

    // mode request
    if (req == REQ_CHARGE) begin
      if (ph == PH_OFF || ph == PH_BAL) ph = PH_INIT;
    end else if (req == REQ_BALANCE) begin
      if (ph == PH_OFF || ph == PH_CC || ph == PH_CV) ph = PH_INIT;
    end else if (ph != PH_OFF) begin
      ph = PH_DONE;
    end

    case (ph)
      PH_INIT: begin
        want = (req == REQ_CHARGE);
        cmd  = make_cmd(want, 1'b0, '0, '0);
        if (closed == want) begin
          if (req == REQ_CHARGE) ph = (cmax < cell_lim_mv) ? PH_CC : PH_CV;
          else if (req == REQ_BALANCE) ph = PH_BAL;
        end
      end
      PH_CC: begin
        if (cmax >= cell_lim_mv) begin
          ph  = PH_CV;
          cmd = make_cmd(1'b1, 1'b1, cv_volt_mv, chg_curr_ma);
        end else begin
          cmd = make_cmd(1'b1, 1'b1, cc_volt_mv, chg_curr_ma);
        end
        if (!closed) begin
          cmd = make_cmd(1'b1, 1'b0, '0, '0);
          ph  = PH_INIT;
        end
      end
      PH_CV: begin
        finished = 1'b0;
        if (cmax < cell_lim_mv) begin
          ph  = PH_CC;
          cmd = make_cmd(1'b1, 1'b1, cc_volt_mv, chg_curr_ma);
        end else begin
          cmd = make_cmd(1'b1, 1'b1, cv_volt_mv, chg_curr_ma);
          if (cur < taper_curr_ma) begin
            // wrapping tick difference
            elapsed = ticks - last_high_tick;
            if (elapsed >= taper_time_ms) begin
              cmd      = '0;
              ph       = PH_DONE;
              finished = 1'b1;
            end
          end else begin
            last_high_tick = ticks;
          end
        end
        if (!finished && !closed) begin
          cmd = make_cmd(1'b1, 1'b0, '0, '0);
          ph  = PH_INIT;
        end
      end
      PH_BAL: begin
        if (!bal_req) ph = PH_DONE;
        if (closed) ph = PH_INIT;
      end
      PH_DONE: begin
        if (req == REQ_CHARGE) begin
          if (cmax < cell_lim_mv) ph = PH_INIT;
        end else if (req == REQ_BALANCE) begin
          // any of the first n stored cells above target plus margin restarts
          n = (int'(cells_used) < MAX_CELLS) ? int'(cells_used) : MAX_CELLS;
          bal_limit = {1'b0, bal_mv} + {1'b0, bal_margin_mv};
          for (int i = 0; i < n; i++) begin
            if ({1'b0, cell_mv_store[i]} > bal_limit) ph = PH_INIT;
          end
        end else if (!closed && !chg_on) begin
          ph = PH_OFF;
        end
      end
      default: ;
    endcase

    cur_phase = ph;
    cmd.state = ph;
    return cmd;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_cnt++;
  endtask

  always @(posedge clk) begin
    charger_cmd_t want;
    if (rst) begin
      cell_lim_mv    = CELL_MAX_RESET;
      cc_volt_mv     = '0;
      cv_volt_mv     = '0;
      chg_curr_ma    = '0;
      taper_curr_ma  = '0;
      taper_time_ms  = '0;
      bal_margin_mv  = '0;
      cells_used     = '0;
      cur_phase      = PH_OFF;
      last_high_tick = '0;
      foreach (cell_mv_store[i]) cell_mv_store[i] = '0;
      predicted_cmds.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_CELL_MAX:     cell_lim_mv   = cfg_data[15:0];
          REG_CC_VOLTAGE:   cc_volt_mv    = cfg_data[22:0];
          REG_CV_VOLTAGE:   cv_volt_mv    = cfg_data[22:0];
          REG_CHARGE_CUR:   chg_curr_ma   = cfg_data[19:0];
          REG_CV_DONE_CUR:  taper_curr_ma = cfg_data[19:0];
          REG_CV_DONE_TIME: taper_time_ms = cfg_data[31:0];
          REG_BAL_THRESH:   bal_margin_mv = cfg_data[15:0];
          REG_NUM_CELLS:    cells_used    = cfg_data[7:0];
          default: ;
        endcase
      end

      // result side
      if (step_out.valid && step_out.ready) begin
        if (predicted_cmds.size() == 0) begin
          report_mismatch("result with no request pending",
                          32'(step_out.phase_out), 32'd0);
        end else begin
          want = predicted_cmds.pop_front();
          if (step_out.contactor_cmd !== want.close)
            report_mismatch("contactor_cmd", 32'(step_out.contactor_cmd),
                            32'(want.close));
          if (step_out.charger_enable !== want.enable)
            report_mismatch("charger_enable", 32'(step_out.charger_enable),
                            32'(want.enable));
          if (step_out.voltage_req_mv !== want.volt_mv)
            report_mismatch("voltage_req_mv", 32'(step_out.voltage_req_mv),
                            32'(want.volt_mv));
          if (step_out.curr_setpt_ma !== want.curr_ma)
            report_mismatch("curr_setpt_ma", 32'(step_out.curr_setpt_ma),
                            32'(want.curr_ma));
          if (step_out.phase_out !== want.state)
            report_mismatch("phase_out", 32'(step_out.phase_out), 32'(want.state));
        end
      end

      // request side
      if (step_in.valid && step_in.ready) begin
        if (step_in.mode == MODE_STEP)
          predicted_cmds.push_back(advance_charge_phase(
            step_in.request, step_in.contactor_fb, step_in.charger_is_on,
            step_in.bal_hold, step_in.hi_cell_mv, step_in.pack_current_ma,
            step_in.ms_ticks, step_in.bal_target_mv));
        else
          cell_mv_store[step_in.cell_index] = step_in.cell_mv;
      end
    end
    pending <= predicted_cmds.size();
  end

endmodule

FILE: tb/cc_cv_charge_controller_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cc_cv_charge_controller_test
// Drives the charge controller through several register settings, extremes
// included: a directed walk through every phase, then random charge, balance
// and leave sessions with cell writes and noise, random stalls on both channels
// save in the last setting. The checker beside the block predicts and compares.
// ---------------------------------------------------------------------------
module cc_cv_charge_controller_test;
  import ccc_pkg::*;

  localparam int NUM_PHASES   = 6;
  localparam int ITEMS_PHASE  = 225;
  localparam int DIRECTED_CNT = 25;

  // leave requests: both codes end charging or balancing
  localparam req_t REQ_LEAVE     = 2'd2;
  localparam req_t REQ_LEAVE_ALT = 2'd3;

  typedef struct packed {
    logic        mode;
    logic [6:0]  cell_index;
    logic [15:0] cell_mv;
    req_t        request;
    logic        closed;
    logic        chg_on;
    logic        bal_req;
    logic [15:0] cmax;
    logic [19:0] cur;
    logic [31:0] ticks;
    logic [15:0] bal_mv;
  } ccc_item_t;

  localparam int ITEM_W = $bits(ccc_item_t);

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_we;
  cfg_idx_t          cfg_index;
  logic [CFG_DW-1:0] cfg_data;
  int                failures;
  int                pending;

  ccc_in_if  step_in ();
  ccc_out_if step_out ();

  // stimulus-side view of the settings, used to shape the items
  logic [15:0] cell_lim_mv;
  logic [19:0] taper_curr_ma;
  int          cells_in_use;
  logic [31:0] tick_now;
  bit          idling_on = 1'b1;

  cc_cv_charge_controller dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step_in   (step_in),
    .step_out  (step_out)
  );

  cc_cv_charge_controller_check result_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step_in   (step_in),
    .step_out  (step_out),
    .failures  (failures),
    .pending   (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // run guard
  initial begin
    #15_000_000;
    $display("cc_cv_charge_controller_test: done, errors");
    $finish;
  end

  // result side stalls
  initial begin
    step_out.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (idling_on && $urandom_range(0, 11) == 0) begin
        step_out.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        step_out.ready <= 1'b1;
      end
    end
  end

  task automatic send_item(input ccc_item_t it);
    step_in.valid           <= 1'b1;
    step_in.mode            <= it.mode;
    step_in.cell_index      <= it.cell_index;
    step_in.cell_mv         <= it.cell_mv;
    step_in.request         <= it.request;
    step_in.contactor_fb    <= it.closed;
    step_in.charger_is_on   <= it.chg_on;
    step_in.bal_hold        <= it.bal_req;
    step_in.hi_cell_mv      <= it.cmax;
    step_in.pack_current_ma <= it.cur;
    step_in.ms_ticks        <= it.ticks;
    step_in.bal_target_mv   <= it.bal_mv;
    @(posedge clk);
    while (!step_in.ready) @(posedge clk);
    // sender gap
    if (idling_on && $urandom_range(0, 3) == 0) begin
      step_in.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic control_step(req_t req, logic closed, logic chg_on, logic bal_req,
                              logic [15:0] cmax, logic [19:0] cur,
                              logic [31:0] ticks, logic [15:0] bal_mv);
    ccc_item_t it;
    it            = '0;
    it.mode       = MODE_STEP;
    it.cell_index = 7'($urandom);
    it.cell_mv    = 16'($urandom);
    it.request    = req;
    it.closed     = closed;
    it.chg_on     = chg_on;
    it.bal_req    = bal_req;
    it.cmax       = cmax;
    it.cur        = cur;
    it.ticks      = ticks;
    it.bal_mv     = bal_mv;
    send_item(it);
  endtask

  // other fields random: the block must ignore them on a cell write
  task automatic cell_write(logic [6:0] idx, logic [15:0] mv);
    ccc_item_t it;
    it            = ccc_item_t'(ITEM_W'({$urandom, $urandom, $urandom, $urandom}));
    it.mode       = MODE_CELL_WRITE;
    it.cell_index = idx;
    it.cell_mv    = mv;
    send_item(it);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic program_regs(logic [15:0] lim, logic [22:0] cc_mv, logic [22:0] cv_mv,
                              logic [19:0] chg_ma, logic [19:0] taper_ma,
                              logic [31:0] taper_ms, logic [15:0] margin,
                              logic [7:0] ncells);
    write_reg(REG_CELL_MAX, 32'(lim));
    write_reg(REG_CC_VOLTAGE, 32'(cc_mv));
    write_reg(REG_CV_VOLTAGE, 32'(cv_mv));
    write_reg(REG_CHARGE_CUR, 32'(chg_ma));
    write_reg(REG_CV_DONE_CUR, 32'(taper_ma));
    write_reg(REG_CV_DONE_TIME, taper_ms);
    write_reg(REG_BAL_THRESH, 32'(margin));
    write_reg(REG_NUM_CELLS, 32'(ncells));
    cfg_we        <= 1'b0;
    cell_lim_mv   = lim;
    taper_curr_ma = taper_ma;
    cells_in_use  = (int'(ncells) < MAX_CELLS) ? int'(ncells) : MAX_CELLS;
  endtask

  // stop sending and wait for every predicted result
  task automatic settle_results(int extra_cycles);
    step_in.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (extra_cycles) @(posedge clk);
  endtask

  // walk through every phase
  task automatic run_directed();
    cell_write(7'd0, 16'hFFFF);
    cell_write(7'd127, 16'h0000);
    cell_write(7'd64, 16'd3900);
    control_step(REQ_CHARGE, 1'b0, 1'b0, 1'b0, 16'd4000, 20'd0, 32'd0, 16'd0);
    control_step(REQ_CHARGE, 1'b1, 1'b1, 1'b0, 16'd4000, 20'hFFFFF, 32'd10, 16'd0);
    control_step(REQ_CHARGE, 1'b1, 1'b1, 1'b0, 16'd4000, 20'd2000, 32'd20, 16'd0);
    // contactor opens during cc
    control_step(REQ_CHARGE, 1'b0, 1'b1, 1'b0, 16'd4000, 20'd2000, 32'd30, 16'd0);
    control_step(REQ_CHARGE, 1'b1, 1'b1, 1'b0, 16'hFFFF, 20'd2000, 32'd40, 16'd0);
    // high current just before the tick wraps
    control_step(REQ_CHARGE, 1'b1, 1'b1, 1'b0, 16'hFFFF, 20'hFFFFF, 32'hFFFF_FFF0, 16'd0);
    control_step(REQ_CHARGE, 1'b1, 1'b1, 1'b0, 16'hFFFF, 20'd0, 32'h0000_0010, 16'd0);
    // contactor opens during cv
    control_step(REQ_CHARGE, 1'b0, 1'b1, 1'b0, 16'd4300, 20'd0, 32'h0000_0020, 16'd0);
    control_step(REQ_CHARGE, 1'b1, 1'b1, 1'b0, 16'd4300, 20'd0, 32'h0000_0030, 16'd0);
    control_step(REQ_CHARGE, 1'b1, 1'b1, 1'b0, 16'd4300, 20'd0, 32'h0000_0070, 16'd0);
    control_step(REQ_CHARGE, 1'b1, 1'b1, 1'b1, 16'd4300, 20'd0, 32'h0000_0080, 16'd0);
    // balance check with the largest target finds nothing
    control_step(REQ_BALANCE, 1'b1, 1'b0, 1'b1, 16'd4300, 20'd0, 32'h0000_0090, 16'hFFFF);
    control_step(REQ_BALANCE, 1'b1, 1'b0, 1'b1, 16'd4300, 20'd0, 32'h0000_00A0, 16'd3000);
    control_step(REQ_BALANCE, 1'b0, 1'b0, 1'b1, 16'd4300, 20'd0, 32'h0000_00B0, 16'd3000);
    control_step(REQ_BALANCE, 1'b0, 1'b0, 1'b1, 16'd4300, 20'd0, 32'h0000_00C0, 16'd3000);
    control_step(REQ_BALANCE, 1'b0, 1'b0, 1'b0, 16'd4300, 20'd0, 32'h0000_00D0, 16'd3000);
    // the second leave code acts like the first
    control_step(REQ_LEAVE_ALT, 1'b1, 1'b1, 1'b0, 16'd4300, 20'd0, 32'h0000_00E0, 16'd0);
    control_step(REQ_LEAVE, 1'b0, 1'b0, 1'b0, 16'd4300, 20'd0, 32'h0000_00F0, 16'd0);
    control_step(REQ_LEAVE, 1'b0, 1'b0, 1'b0, 16'd4300, 20'd0, 32'h0000_0100, 16'd0);
    control_step(REQ_BALANCE, 1'b0, 1'b0, 1'b1, 16'd4300, 20'd0, 32'h0000_0110, 16'd0);
    control_step(REQ_BALANCE, 1'b1, 1'b0, 1'b1, 16'd4300, 20'd0, 32'h0000_0120, 16'd0);
    control_step(REQ_CHARGE, 1'b1, 1'b0, 1'b0, 16'd4000, 20'd0, 32'h0000_0130, 16'd0);
  endtask

  // random sessions: charge, balance, leave and noise, with cell writes mixed in
  task automatic run_random(int count);
    int          n;
    int          kind;
    int          len;
    int          taper_at;
    int          ramp;
    int          hi;
    logic [15:0] cmax;
    logic [19:0] cur;
    logic [15:0] bal_tgt;
    n = 0;
    while (n < count) begin
      kind     = $urandom_range(0, 19);
      len      = $urandom_range(3, 30);
      taper_at = $urandom_range(0, len);
      ramp     = int'(cell_lim_mv) - int'($urandom_range(0, 200));
      bal_tgt  = 16'($urandom_range(2900, 4300));
      for (int s = 0; s < len && n < count; s++) begin
        n++;
        if ($urandom_range(0, 6) == 0) begin
          cell_write((cells_in_use > 0 && $urandom_range(0, 3) != 0) ?
                       7'($urandom_range(0, cells_in_use - 1)) : 7'($urandom),
                     ($urandom_range(0, 4) != 0) ?
                       16'($urandom_range(2800, 4400)) : 16'($urandom));
          continue;
        end
        tick_now += $urandom_range(0, 40);
        if ($urandom_range(0, 49) == 0) tick_now = $urandom;
        if (kind < 10) begin
          // charge: cells climb toward the limit, current tapers off
          ramp += $urandom_range(0, 40);
          cmax = (ramp < 0) ? 16'd0 : (ramp > 65535) ? 16'hFFFF : 16'(ramp);
          if (s >= taper_at && $urandom_range(0, 19) != 0) begin
            cur = (taper_curr_ma == 0) ? 20'd0 :
                  20'($urandom_range(0, int'(taper_curr_ma) - 1));
          end else begin
            hi  = int'(taper_curr_ma) + 5000;
            if (hi > 20'hFFFFF) hi = 20'hFFFFF;
            cur = 20'($urandom_range(int'(taper_curr_ma), hi));
          end
          control_step(REQ_CHARGE, $urandom_range(0, 9) != 0, 1'($urandom), 1'($urandom),
                       cmax, cur, tick_now, 16'($urandom));
        end else if (kind < 15) begin
          control_step(REQ_BALANCE, $urandom_range(0, 7) == 0, 1'($urandom),
                       (s < len - 2) && ($urandom_range(0, 9) != 0), 16'($urandom),
                       20'($urandom), tick_now,
                       bal_tgt + 16'($urandom_range(0, 300)) - 16'd150);
        end else if (kind < 18) begin
          control_step(($urandom_range(0, 1) == 0) ? REQ_LEAVE : REQ_LEAVE_ALT,
                       $urandom_range(0, 3) == 0,
                       $urandom_range(0, 3) == 0, 1'($urandom), 16'($urandom),
                       20'($urandom), tick_now, 16'($urandom));
        end else begin
          control_step(req_t'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                       16'($urandom), 20'($urandom), $urandom, 16'($urandom));
        end
      end
    end
  endtask

  initial begin
    rst                     <= 1'b1;
    cfg_we                  <= 1'b0;
    cfg_index               <= REG_CELL_MAX;
    cfg_data                <= '0;
    step_in.valid           <= 1'b0;
    step_in.mode            <= MODE_STEP;
    step_in.cell_index      <= '0;
    step_in.cell_mv         <= '0;
    step_in.request         <= REQ_CHARGE;
    step_in.contactor_fb    <= 1'b0;
    step_in.charger_is_on   <= 1'b0;
    step_in.bal_hold        <= 1'b0;
    step_in.hi_cell_mv      <= '0;
    step_in.pack_current_ma <= '0;
    step_in.ms_ticks        <= '0;
    step_in.bal_target_mv   <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) settle_results(4);
      case (ph)
        0: program_regs(16'd4200, 23'd403200, 23'd412000, 20'd30000, 20'd1500,
                        32'd100, 16'd20, 8'd128);
        1: program_regs(16'd0, 23'h7FFFFF, 23'd0, 20'hFFFFF, 20'hFFFFF,
                        32'hFFFF_FFFF, 16'hFFFF, 8'd0);
        2: program_regs(16'hFFFF, 23'd0, 23'h7FFFFF, 20'd0, 20'd0,
                        32'd0, 16'd0, 8'd255);
        default: program_regs(16'($urandom_range(3000, 4300)), 23'($urandom),
                              23'($urandom), 20'($urandom),
                              20'($urandom_range(100, 5000)),
                              32'($urandom_range(10, 400)),
                              16'($urandom_range(0, 200)),
                              8'($urandom_range(1, 16)));
      endcase
      if (ph == 0) begin
        run_directed();
        tick_now = 32'hFFFF_F000;
      end
      if (ph == NUM_PHASES - 1) idling_on = 1'b0;
      run_random((ph == 0) ? ITEMS_PHASE - DIRECTED_CNT : ITEMS_PHASE);
    end

    settle_results(140);
    if (failures == 0 && pending == 0) begin
      $display("cc_cv_charge_controller_test: done, clean");
    end else begin
      $display("cc_cv_charge_controller_test: done, errors");
    end
    $finish;
  end

endmodule

FILE: files.f
design/ccc_pkg.sv
design/ccc_in_if.sv
design/ccc_out_if.sv
design/ccc_ram.sv
design/cc_cv_charge_controller.sv
tb/cc_cv_charge_controller_check.sv
tb/cc_cv_charge_controller_test.sv
